[rtl/core/stbs_pkg.sv]
// Shared types, widths and codes for the sorted key table with binary search.
package stbs_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int KEY_W    = 32;
  localparam int PRICE_W  = 24;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 4;
  localparam int COUNT_W  = 5;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic                      operation;
    logic signed [KEY_W-1:0]   key;
    logic        [PRICE_W-1:0] price;
  } req_t;

  typedef struct packed {
    logic        [STATUS_W-1:0] status;
    logic        [SLOT_W-1:0]   found_slot;
    logic signed [KEY_W-1:0]    found_key;
    logic        [PRICE_W-1:0]  found_price;
    logic        [COUNT_W-1:0]  entry_count;
  } res_t;

endpackage

[rtl/core/sorted_table_binary_search_top.sv]
// Top level of the sorted key table with binary search and its stream ports.
//
// Usage: each item on the slave stream either inserts a (key, price) entry or
// searches for a key. s_axis_tuser carries the operation (0 insert,
// 1 search); s_axis_tdata carries key then price. Every item yields exactly
// one result on the master stream: m_axis_tuser is the status (inserted,
// full, found, not found), m_axis_tdata carries slot, key, price and the
// entry count after the item.
// Sequencing: one item is worked at a time by a sequencer around a single
// memory read port and one signed key comparator. An insert on a full table
// is refused and one on an empty table writes slot 0 directly; otherwise it
// walks down from the top entry, moving each entry with a larger key up one
// slot, then writes the new one. A search probes the middle of the remaining
// range until a hit or an empty range. The next item can be taken once the
// result has entered the output register.
// Reset: rst (synchronous) empties the table and drops any pending result;
// the table memory itself is not cleared, only the fill count.
// Stall: a result waits in the output register while m_axis_tready is low;
// the next item may be taken and worked meanwhile, and its result is held in
// the sequencer until the output register frees up.
module sorted_table_binary_search_top #(
  parameter int CAPACITY = stbs_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // key[31:0], price[55:32]
  input  logic        s_axis_tuser,  // operation[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // found_slot[3:0], found_key[35:4],
                                     // found_price[59:36], entry_count[64:60]
  output logic [1:0]  m_axis_tuser   // status[1:0]
);
  import stbs_pkg::*;

  req_t req;
  res_t res;
  logic res_valid;
  logic res_ready;
  res_t out_q;

  // Unpack the slave item.
  assign req.operation = s_axis_tuser;
  assign req.key       = s_axis_tdata[KEY_W-1:0];
  assign req.price     = s_axis_tdata[KEY_W+PRICE_W-1:KEY_W];

  stbs_engine #(
    .CAPACITY (CAPACITY)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_axis_tvalid),
    .req_ready (s_axis_tready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: load when empty or being drained this cycle.
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // Hold payload until taken.
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tuser = out_q.status;
  assign m_axis_tdata = {7'b0, out_q.entry_count, out_q.found_price,
                         out_q.found_key, out_q.found_slot};

endmodule

[rtl/core/stbs_engine.sv]
// Table memory, shared key comparator and the insert/search sequencer.
module stbs_engine #(
  parameter int CAPACITY = stbs_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  stbs_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_ready,
  output stbs_pkg::res_t res
);
  import stbs_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = KEY_W + PRICE_W;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_INS_CMP   = 3'd1;
  localparam logic [2:0] S_INS_PUT   = 3'd2;
  localparam logic [2:0] S_SRCH_ADDR = 3'd3;
  localparam logic [2:0] S_SRCH_CMP  = 3'd4;
  localparam logic [2:0] S_DONE      = 3'd5;

  logic [EW-1:0] mem [CAPACITY];
  logic [EW-1:0] rd_data;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  logic [2:0]               state;
  logic [CW-1:0]            count;
  logic [CW-1:0]            pos;
  logic signed [KEY_W-1:0]  op_key;
  logic [PRICE_W-1:0]       op_price;
  logic signed [CW:0]       low;
  logic signed [CW:0]       high;
  logic signed [CW:0]       mid;
  logic [STATUS_W-1:0]      res_status;
  logic [IW-1:0]            res_slot;
  logic signed [KEY_W-1:0]  res_key;
  logic [PRICE_W-1:0]       res_price;

  logic [CW-1:0]            cnt_m1;
  logic [CW-1:0]            pos_m1;
  logic [CW-1:0]            pos_m2;
  logic signed [CW+1:0]     mid_sum;
  logic signed [CW:0]       mid_calc;
  logic signed [KEY_W-1:0]  rd_key;
  logic                     key_lt;
  logic                     key_eq;
  logic                     key_gt;
  logic                     accept;
  logic [IW+SLOT_W-1:0]     slot_ext;
  logic [CW+COUNT_W-1:0]    count_ext;

  // Table storage: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Shared comparator: stored key against the operand key.
  assign rd_key = rd_data[KEY_W-1:0];
  assign key_lt = rd_key < op_key;
  assign key_eq = rd_key == op_key;
  assign key_gt = !key_lt && !key_eq;

  assign cnt_m1   = count - CW'(1);
  assign pos_m1   = pos - CW'(1);
  assign pos_m2   = pos - CW'(2);
  assign mid_sum  = {low[CW], low} + {high[CW], high};
  assign mid_calc = mid_sum[CW+1:1];

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;

  always_comb begin
    unique case (state)
      S_IDLE:    rd_addr = cnt_m1[IW-1:0];
      S_INS_CMP: rd_addr = pos_m2[IW-1:0];
      default:   rd_addr = mid_calc[IW-1:0];
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos[IW-1:0];
    wr_data = {op_price, op_key};
    unique case (state)
      S_IDLE: begin
        if (accept && req.operation == OP_INSERT && count == '0) begin
          wr_en   = 1'b1;
          wr_addr = '0;
          wr_data = {req.price, req.key};
        end
      end
      S_INS_CMP: begin
        wr_en = 1'b1;
        if (key_gt) begin
          wr_data = rd_data;
        end
      end
      S_INS_PUT: begin
        wr_en = 1'b1;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_key    <= req.key;
            op_price  <= req.price;
            res_slot  <= '0;
            res_key   <= '0;
            res_price <= '0;
            if (req.operation == OP_INSERT) begin
              if (count == CW'(CAPACITY)) begin
                res_status <= ST_FULL;
                state      <= S_DONE;
              end else if (count == '0) begin
                res_status <= ST_INSERTED;
                count      <= count + CW'(1);
                state      <= S_DONE;
              end else begin
                res_status <= ST_INSERTED;
                pos        <= count;
                state      <= S_INS_CMP;
              end
            end else begin
              res_status <= ST_NOT_FOUND;
              low        <= '0;
              high       <= $signed({1'b0, count}) - (CW+1)'(1);
              state      <= S_SRCH_ADDR;
            end
          end
        end
        S_INS_CMP: begin
          if (key_gt) begin
            pos   <= pos_m1;
            state <= (pos_m1 == '0) ? S_INS_PUT : S_INS_CMP;
          end else begin
            count <= count + CW'(1);
            state <= S_DONE;
          end
        end
        S_INS_PUT: begin
          count <= count + CW'(1);
          state <= S_DONE;
        end
        S_SRCH_ADDR: begin
          if (low <= high) begin
            mid   <= mid_calc;
            state <= S_SRCH_CMP;
          end else begin
            state <= S_DONE;
          end
        end
        S_SRCH_CMP: begin
          if (key_eq) begin
            res_status <= ST_FOUND;
            res_slot   <= mid[IW-1:0];
            res_key    <= rd_key;
            res_price  <= rd_data[EW-1:KEY_W];
            state      <= S_DONE;
          end else if (key_lt) begin
            low   <= mid + (CW+1)'(1);
            state <= S_SRCH_ADDR;
          end else begin
            high  <= mid - (CW+1)'(1);
            state <= S_SRCH_ADDR;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign slot_ext  = {{SLOT_W{1'b0}}, res_slot};
  assign count_ext = {{COUNT_W{1'b0}}, count};

  assign res_valid       = (state == S_DONE);
  assign res.status      = res_status;
  assign res.found_slot  = slot_ext[SLOT_W-1:0];
  assign res.found_key   = res_key;
  assign res.found_price = res_price;
  assign res.entry_count = count_ext[COUNT_W-1:0];

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && count != $past(count)) |-> (count == $past(count) + CW'(1)))
    else $error("entry count moved by other than one");

  a_found_slot: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_status == ST_FOUND) |-> (CW'(res_slot) < count))
    else $error("hit slot outside stored entries");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_status == ST_INSERTED) |-> (count != '0))
    else $error("insert reported with empty table");
`endif

endmodule

[bench/stbs_checker.sv]
// Checker: predicts every result of the sorted key table and compares it.
`timescale 1ns / 100ps
module stbs_checker #(
  parameter int DEPTH = stbs_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // key[31:0], price[55:32]
  input  logic        s_axis_tuser,   // operation[0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [71:0] m_axis_tdata,   // found_slot[3:0], found_key[35:4],
                                      // found_price[59:36], entry_count[64:60]
  input  logic [1:0]  m_axis_tuser,   // status[1:0]
  output int          errors,
  output int          outstanding,
  output int          hits,
  output int          misses,
  output int          fulls
);
  import stbs_pkg::*;

  logic signed [KEY_W-1:0]   shelf_key   [DEPTH];
  logic        [PRICE_W-1:0] shelf_price [DEPTH];
  int                        shelf_fill;
  res_t                      pending_results[$];
  res_t                      got_res;
  res_t                      want_res;
  req_t                      req;

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
  endtask

  // Apply one item to the shadow table and return the result it should give.
  function automatic res_t table_step(input req_t rq);
    res_t                      r;
    int                        lo;
    int                        hi;
    int                        mid;
    int                        j;
    logic signed [KEY_W-1:0]   want_key;
    logic signed [KEY_W-1:0]   tk;
    logic        [PRICE_W-1:0] tp;
    r        = '0;
    want_key = rq.key;
    if (rq.operation == OP_INSERT) begin
      if (shelf_fill < DEPTH) begin
        j = shelf_fill;
        shelf_key[j]   = want_key;
        shelf_price[j] = rq.price;
        shelf_fill++;
        // move the new entry down past strictly larger keys; ties keep order
        while (j > 0 && shelf_key[j-1] > shelf_key[j]) begin
          tk               = shelf_key[j-1];
          tp               = shelf_price[j-1];
          shelf_key[j-1]   = shelf_key[j];
          shelf_price[j-1] = shelf_price[j];
          shelf_key[j]     = tk;
          shelf_price[j]   = tp;
          j--;
        end
        r.status = ST_INSERTED;
      end else begin
        r.status = ST_FULL;
      end
    end else begin
      r.status = ST_NOT_FOUND;
      lo = 0;
      hi = shelf_fill - 1;
      while (lo <= hi) begin
        mid = (lo + hi) / 2;
        if (shelf_key[mid] == want_key) begin
          r.status      = ST_FOUND;
          r.found_slot  = mid[SLOT_W-1:0];
          r.found_key   = shelf_key[mid];
          r.found_price = shelf_price[mid];
          break;
        end else if (shelf_key[mid] < want_key) begin
          lo = mid + 1;
        end else begin
          hi = mid - 1;
        end
      end
    end
    r.entry_count = shelf_fill[COUNT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      pending_results.delete();
      shelf_fill = 0;
      errors     = 0;
      hits       = 0;
      misses     = 0;
      fulls      = 0;
      outstanding <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_res.status      = m_axis_tuser;
        got_res.found_slot  = m_axis_tdata[3:0];
        got_res.found_key   = m_axis_tdata[35:4];
        got_res.found_price = m_axis_tdata[59:36];
        got_res.entry_count = m_axis_tdata[64:60];
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing expected", 32'(got_res.status), '0);
        end else begin
          want_res = pending_results.pop_front();
          if (got_res.status !== want_res.status)
            report_mismatch("status", 32'(got_res.status), 32'(want_res.status));
          if (got_res.found_slot !== want_res.found_slot)
            report_mismatch("found_slot", 32'(got_res.found_slot),
                            32'(want_res.found_slot));
          if (got_res.found_key !== want_res.found_key)
            report_mismatch("found_key", got_res.found_key, want_res.found_key);
          if (got_res.found_price !== want_res.found_price)
            report_mismatch("found_price", 32'(got_res.found_price),
                            32'(want_res.found_price));
          if (got_res.entry_count !== want_res.entry_count)
            report_mismatch("entry_count", 32'(got_res.entry_count),
                            32'(want_res.entry_count));
          case (want_res.status)
            ST_FOUND:     hits++;
            ST_NOT_FOUND: misses++;
            ST_FULL:      fulls++;
            default:      ;
          endcase
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        req.operation = s_axis_tuser;
        req.key       = s_axis_tdata[31:0];
        req.price     = s_axis_tdata[55:32];
        pending_results.push_back(table_step(req));
      end
      outstanding <= pending_results.size();
    end
  end

endmodule

[bench/tb.sv]
// Testbench top: drives inserts and searches into the sorted key table.
`timescale 1ns / 100ps
module tb;
  import stbs_pkg::*;

  localparam int RANDOM_ITEMS = 1000;
  localparam int CALM_ITEMS   = 150;   // tail of the run with no idling at all

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata  = '0;     // key[31:0], price[55:32]
  logic        s_axis_tuser  = 1'b0;   // operation[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;           // found_slot[3:0], found_key[35:4],
                                       // found_price[59:36], entry_count[64:60]
  logic [1:0]  m_axis_tuser;           // status[1:0]

  int mismatches;
  int outstanding;
  int hits;
  int misses;
  int fulls;

  // Idling controls shared by the sender and the receiver.
  bit calm      = 1'b0;
  int gap_pct   = 30;
  int stall_pct = 30;
  int stall_left;

  // Stimulus bookkeeping: keys that found room in the table, item counts.
  logic [31:0] known_keys[$];
  int          inserts_sent;
  int          searches_sent;

  always #5 clk = ~clk;

  sorted_table_binary_search_top u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  stbs_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .errors        (mismatches),
    .outstanding   (outstanding),
    .hits          (hits),
    .misses        (misses),
    .fulls         (fulls)
  );

  // Result side: hold tready low in random bursts.
  always @(posedge clk) begin
    if (rst || calm) begin
      m_axis_tready <= 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(99) < stall_pct) begin
      m_axis_tready <= 1'b0;
      stall_left = $urandom_range(6, 1) - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Present one item, hold it until taken, then maybe idle for a burst.
  task automatic send_item(input logic op, input logic [31:0] k, input logic [23:0] p);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {p, k};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (op == OP_INSERT) begin
      inserts_sent++;
      if (known_keys.size() < CAPACITY_DEF) known_keys.push_back(k);
    end else begin
      searches_sent++;
    end
    if (!calm && $urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  endtask

  // Drop valid and hold off until every expected result has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Insert keys: wide random, a narrow cluster around zero for ties and
  // neighbors, repeats of stored keys, and the signed extremes.
  function automatic logic [31:0] pick_insert_key();
    int r;
    r = $urandom_range(99);
    if (r < 35) return $urandom;
    if (r < 65) return $urandom_range(20) - 10;
    if (r < 85 && known_keys.size() != 0)
      return known_keys[$urandom_range(known_keys.size() - 1)];
    case ($urandom_range(3))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h8000_0001;
      default: return 32'h7FFF_FFFE;
    endcase
  endfunction

  // Search keys: mostly stored keys and their direct neighbors, some random.
  function automatic logic [31:0] pick_probe_key();
    int          r;
    logic [31:0] pk;
    r = $urandom_range(99);
    if (known_keys.size() == 0 || r >= 80) return $urandom;
    pk = known_keys[$urandom_range(known_keys.size() - 1)];
    if (r < 55) return pk;
    if (r < 68) return pk + 1;
    return pk - 1;
  endfunction

  initial begin
    logic op;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty-table searches, signed extremes, price extremes,
    // duplicate keys, hits and misses between stored keys.
    send_item(OP_SEARCH, 32'h0000_0000, 24'hFFFFFF);
    send_item(OP_SEARCH, 32'h8000_0000, 24'h000000);
    send_item(OP_INSERT, 32'h7FFF_FFFF, 24'hFFFFFF);
    send_item(OP_SEARCH, 32'h7FFF_FFFF, 24'h123456);
    send_item(OP_INSERT, 32'h8000_0000, 24'h000000);
    send_item(OP_SEARCH, 32'h8000_0000, 24'hFFFFFF);
    send_item(OP_SEARCH, 32'h7FFF_FFFF, 24'h000000);
    send_item(OP_INSERT, 32'd5,         24'd100);
    send_item(OP_INSERT, 32'd5,         24'd200);
    send_item(OP_INSERT, 32'hFFFF_FFFF, 24'hABCDEF);
    send_item(OP_SEARCH, 32'd5,         24'h000000);
    send_item(OP_SEARCH, 32'hFFFF_FFFF, 24'h000000);
    send_item(OP_SEARCH, 32'd4,         24'h000000);
    send_item(OP_SEARCH, 32'd6,         24'h000000);
    send_item(OP_SEARCH, 32'h7FFF_FFFE, 24'h000000);
    send_item(OP_SEARCH, 32'h8000_0001, 24'h000000);
    send_item(OP_INSERT, 32'h0000_0000, 24'h800000);
    send_item(OP_SEARCH, 32'h0000_0000, 24'h000000);
    send_item(OP_SEARCH, 32'h0000_0001, 24'h000000);

    // Random: the table fills slowly so searches see every fill level,
    // then inserts keep hitting the full table.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) begin
        case ($urandom_range(2))
          0:       begin gap_pct = 0;  stall_pct = 0;  end
          1:       begin gap_pct = 15; stall_pct = 20; end
          default: begin gap_pct = 40; stall_pct = 40; end
        endcase
      end
      if (i == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      if (i == 400) drain();
      op = ($urandom_range(99) < 9) ? OP_INSERT : OP_SEARCH;
      if (op == OP_INSERT) send_item(op, pick_insert_key(), 24'($urandom));
      else send_item(op, pick_probe_key(), 24'($urandom));
    end

    // Wait out every pending result plus the block's latency.
    drain();
    repeat (40) @(posedge clk);

    $display("Summary: %0d items (%0d inserts, %0d searches), table holds %0d entries",
             inserts_sent + searches_sent, inserts_sent, searches_sent, known_keys.size());
    $display("Results: %0d found, %0d not found, %0d refused on a full table",
             hits, misses, fulls);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
